// ===== src/yam_pkg.sv =====
// ----------------------------------------------------------------------------
// yam_pkg: shared types and constants
// Payload structs for the YUYV input and ARGB output channels, the address
// bundle passed from the address generator, and the color coefficients.
// ----------------------------------------------------------------------------
package yam_pkg;

  localparam int ADDR_W = 22;

  // Q15 color coefficients
  localparam logic signed [27:0] COEF_RV = 28'sd37221;
  localparam logic signed [27:0] COEF_GU = 28'sd12975;
  localparam logic signed [27:0] COEF_GV = 28'sd18949;
  localparam logic signed [27:0] COEF_BU = 28'sd66883;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [31:0]       pixel_argb;
    logic              last_of_pair;
    logic              frame_end;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_first;
    logic [ADDR_W-1:0] addr_second;
    logic              frame_done;
  } addr_info_t;

endpackage

// ===== src/yuyv_to_argb_mirror_converter.sv =====
// ----------------------------------------------------------------------------
// yuyv_to_argb_mirror_converter: YUYV 4:2:2 to ARGB with mirrored addresses
// Converts one macropixel into two opaque ARGB pixels, each with a
// horizontally mirrored frame-buffer address; width/height over APB.
//
//   channel  direction  handshake            payload
//   yuyv     in         yuyv_valid/stall     yam_pkg::in_t  (one macropixel)
//   argb     out        argb_valid/stall     yam_pkg::out_t (one pixel)
//   apb      in/out     psel/penable/pready  frame_width @0, frame_height @4
//
// Sustained macropixel rate is set by the output port, which carries one pixel
// per cycle unless argb_stall; the input register takes the next macropixel
// as the pair drains. Pixels pass the input register, then the pair register.
// Synchronous reset clears the pipeline and counters; size registers go to
// 640 x 480. No clearing pass after reset. An output stall holds the pixel pair
// and backs up into the input register, then raises yuyv_stall.
// ----------------------------------------------------------------------------
module yuyv_to_argb_mirror_converter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           yuyv_valid,
  output logic           yuyv_stall,
  input  yam_pkg::in_t   yuyv,
  output logic           argb_valid,
  input  logic           argb_stall,
  output yam_pkg::out_t  argb,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  logic [11:0]         frame_width;
  logic [11:0]         frame_height;
  logic                cfg_write;
  logic                reg_sel;

  logic                in_valid;
  yam_pkg::in_t        in_pix;
  yam_pkg::addr_info_t in_info;
  yam_pkg::addr_info_t cur_info;
  logic                in_take;
  logic                pair_load;
  logic                pair_free;
  logic [31:0]         argb_first;
  logic [31:0]         argb_second;

  // configuration port
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 12'd640;
      frame_height <= 12'd480;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[11:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:  prdata = {20'd0, frame_width};
      REG_FRAME_HEIGHT: prdata = {20'd0, frame_height};
      default:          prdata = '0;
    endcase
  end

  // input register: move into the pair register as the previous pair drains
  assign pair_load  = in_valid && pair_free;
  assign yuyv_stall = in_valid && !pair_load;
  assign in_take    = yuyv_valid && !yuyv_stall;

  yam_addr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr_gen (
    .clk          (clk),
    .rst          (rst),
    .advance      (in_take),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .info         (cur_info)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (pair_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_pix  <= yuyv;
      in_info <= cur_info;
    end
  end

  yam_color u_color (
    .pix         (in_pix),
    .argb_first  (argb_first),
    .argb_second (argb_second)
  );

  yam_out_ser u_out_ser (
    .clk         (clk),
    .rst         (rst),
    .load        (pair_load),
    .argb_first  (argb_first),
    .argb_second (argb_second),
    .info        (in_info),
    .stall       (argb_stall),
    .valid       (argb_valid),
    .data        (argb),
    .free        (pair_free)
  );

`ifndef NO_ASSERTIONS
  a_frame_end_on_second: assert property (@(posedge clk) disable iff (rst)
    argb_valid && argb.frame_end |-> argb.last_of_pair)
    else $error("frame_end on first pixel of pair");

  a_second_follows_first: assert property (@(posedge clk) disable iff (rst)
    argb_valid && !argb_stall && !argb.last_of_pair |=> argb_valid && argb.last_of_pair)
    else $error("second pixel of pair not offered after first transfer");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_valid)
    else $error("accepted macropixel lost from input register");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !argb_valid)
    else $error("output valid after reset");
`endif

endmodule

// ===== src/yam_addr_gen.sv =====
// ----------------------------------------------------------------------------
// yam_addr_gen: mirrored frame-buffer address generator
// Column/row counters over the frame; gives both pixel addresses of the
// current macropixel and the frame-end flag, advances on each input transfer.
// ----------------------------------------------------------------------------
module yam_addr_gen #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [11:0]           frame_width,
  input  logic [11:0]           frame_height,
  output yam_pkg::addr_info_t   info
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int FW = (WW > 12) ? WW : 12;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW = RW + 1;
  localparam int HF = (HW > 12) ? HW : 12;
  localparam int AW = yam_pkg::ADDR_W;

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [AW-1:0] row_base_address;

  logic [FW-1:0] fw_even;
  logic [FW-1:0] fw_sat;
  logic [HF-1:0] fh_ext;
  logic [HF-1:0] fh_sat;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic          line_end;
  logic          frame_done;

  // drop bit 0 of the width, then saturate both sizes
  always_comb begin
    fw_even = FW'({frame_width[11:1], 1'b0});
    if (fw_even < FW'(2)) begin
      fw_sat = FW'(2);
    end else if (fw_even > FW'(MAX_WIDTH)) begin
      fw_sat = FW'(MAX_WIDTH);
    end else begin
      fw_sat = fw_even;
    end
    fh_ext = HF'(frame_height);
    if (fh_ext < HF'(1)) begin
      fh_sat = HF'(1);
    end else if (fh_ext > HF'(MAX_HEIGHT)) begin
      fh_sat = HF'(MAX_HEIGHT);
    end else begin
      fh_sat = fh_ext;
    end
  end

  assign w = WW'(fw_sat);
  assign h = HW'(fh_sat);

  assign line_end   = (WW'(column_count) + WW'(2)) >= w;
  assign frame_done = line_end && ((HW'(row_count) + HW'(1)) >= h);

  assign info.addr_first  = row_base_address + AW'(w) - AW'(1) - AW'(column_count);
  assign info.addr_second = row_base_address + AW'(w) - AW'(2) - AW'(column_count);
  assign info.frame_done  = frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      row_count        <= '0;
      row_base_address <= '0;
    end else if (advance) begin
      if (frame_done) begin
        column_count     <= '0;
        row_count        <= '0;
        row_base_address <= '0;
      end else if (line_end) begin
        column_count     <= '0;
        row_count        <= row_count + RW'(1);
        row_base_address <= row_base_address + AW'(w);
      end else begin
        column_count     <= column_count + CW'(2);
      end
    end
  end

endmodule

// ===== src/yam_color.sv =====
// ----------------------------------------------------------------------------
// yam_color: YUV to ARGB color conversion
// Converts both lumas of one macropixel with the shared chroma; Q15
// coefficients, arithmetic right shift, each channel clamped to 0..255.
// ----------------------------------------------------------------------------
module yam_color (
  input  yam_pkg::in_t  pix,
  output logic [31:0]   argb_first,
  output logic [31:0]   argb_second
);

  logic signed [8:0]  u;
  logic signed [8:0]  v;
  logic signed [27:0] prod_rv;
  logic signed [27:0] prod_g;
  logic signed [27:0] prod_bu;
  logic signed [27:0] sh_rv;
  logic signed [27:0] sh_g;
  logic signed [27:0] sh_bu;
  logic signed [11:0] off_r;
  logic signed [11:0] off_g;
  logic signed [11:0] off_b;

  function automatic logic [7:0] clamp_byte(input logic signed [11:0] x);
    logic [7:0] res;
    if (x < 12'sd0) begin
      res = 8'd0;
    end else if (x > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] to_argb(input logic [7:0] y,
                                          input logic signed [11:0] dr,
                                          input logic signed [11:0] dg,
                                          input logic signed [11:0] db);
    logic signed [11:0] ys;
    ys = $signed({4'b0000, y});
    return {yam_pkg::ALPHA_OPAQUE, clamp_byte(ys + dr), clamp_byte(ys - dg),
            clamp_byte(ys + db)};
  endfunction

  // flip the top bit to subtract the 128 offset, then sign-extend
  assign u = $signed({~pix.chroma_blue[7], ~pix.chroma_blue[7], pix.chroma_blue[6:0]});
  assign v = $signed({~pix.chroma_red[7], ~pix.chroma_red[7], pix.chroma_red[6:0]});

  assign prod_rv = 28'(v) * yam_pkg::COEF_RV;
  assign prod_g  = 28'(u) * yam_pkg::COEF_GU + 28'(v) * yam_pkg::COEF_GV;
  assign prod_bu = 28'(u) * yam_pkg::COEF_BU;

  assign sh_rv = prod_rv >>> 15;
  assign sh_g  = prod_g >>> 15;
  assign sh_bu = prod_bu >>> 15;

  assign off_r = sh_rv[11:0];
  assign off_g = sh_g[11:0];
  assign off_b = sh_bu[11:0];

  assign argb_first  = to_argb(pix.luma_first, off_r, off_g, off_b);
  assign argb_second = to_argb(pix.luma_second, off_r, off_g, off_b);

endmodule

// ===== src/yam_out_ser.sv =====
// ----------------------------------------------------------------------------
// yam_out_ser: pixel pair result register and serializer
// Holds both converted pixels of a macropixel and sends them one transfer at
// a time, first pixel first; takes the next pair as the second one leaves.
// ----------------------------------------------------------------------------
module yam_out_ser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [31:0]          argb_first,
  input  logic [31:0]          argb_second,
  input  yam_pkg::addr_info_t  info,
  input  logic                 stall,
  output logic                 valid,
  output yam_pkg::out_t        data,
  output logic                 free
);

  logic                pair_valid;
  logic                phase;
  logic [31:0]         argb0;
  logic [31:0]         argb1;
  yam_pkg::addr_info_t pair_info;

  assign free  = !pair_valid || (phase && !stall);
  assign valid = pair_valid;

  assign data.pixel_address = phase ? pair_info.addr_second : pair_info.addr_first;
  assign data.pixel_argb    = phase ? argb1 : argb0;
  assign data.last_of_pair  = phase;
  assign data.frame_end     = phase && pair_info.frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (load) begin
      pair_valid <= 1'b1;
      phase      <= 1'b0;
    end else if (pair_valid && !stall) begin
      if (phase) begin
        pair_valid <= 1'b0;
        phase      <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      argb0     <= argb_first;
      argb1     <= argb_second;
      pair_info <= info;
    end
  end

endmodule

// ===== tb/tb_yuyv_to_argb_mirror_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuyv_to_argb_mirror_converter: self-checking bench for the YUYV to ARGB
// converter with mirrored frame-buffer addresses.
// A directed table of macropixels runs at the reset frame size. A series of
// frame sizes follows, written over APB, with random macropixels in each.
// Sizes include the minimum, the maximum, odd, zero and oversized values, and
// changes in mid-frame. An in-bench model of the color math and the
// column/row walk predicts both pixels of every transfer. The output stream
// is compared field by field. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_yuyv_to_argb_mirror_converter;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int ITEM_TARGET = 650;
  localparam int TAIL_ITEMS  = 100;
  localparam int LONG_HOLD   = 300;
  localparam int STUCK_LIMIT = 5000;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;

  logic          clk;
  logic          rst        = 1'b1;
  logic          yuyv_valid = 1'b0;
  logic          yuyv_stall;
  yam_pkg::in_t  yuyv       = '0;
  logic          argb_valid;
  logic          argb_stall = 1'b0;
  yam_pkg::out_t argb;
  logic          psel       = 1'b0;
  logic          penable    = 1'b0;
  logic          pwrite     = 1'b0;
  logic [2:0]    paddr      = '0;
  logic [31:0]   pwdata     = '0;
  logic [31:0]   prdata;
  logic          pready;

  yuyv_to_argb_mirror_converter #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .yuyv_valid (yuyv_valid),
    .yuyv_stall (yuyv_stall),
    .yuyv       (yuyv),
    .argb_valid (argb_valid),
    .argb_stall (argb_stall),
    .argb       (argb),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // model copy of registers and frame walk
  logic [11:0] width_reg  = 12'd640;
  logic [11:0] height_reg = 12'd480;
  logic [10:0] col_pos    = '0;
  logic [10:0] row_pos    = '0;
  logic [21:0] row_base   = '0;

  yam_pkg::out_t pixel_queue[$];

  int  macropixels_sent = 0;
  int  pixels_checked   = 0;
  int  frame_ends_seen  = 0;
  int  size_settings    = 0;
  int  error_count      = 0;
  int  stuck_cycles     = 0;
  bit  src_gaps         = 1'b0;
  bit  sink_gaps        = 1'b0;
  bit  hold_request     = 1'b0;

  typedef struct {
    yam_pkg::in_t px;
    bit           typed;
    logic [31:0]  argb_first;
    logic [31:0]  argb_second;
  } directed_row_t;

  directed_row_t directed_rows[16] = '{
    '{'{8'd0,   8'd128, 8'd0,   8'd128}, 1'b1, 32'hFF000000, 32'hFF000000},
    '{'{8'd255, 8'd128, 8'd255, 8'd128}, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{'{8'd0,   8'd0,   8'd255, 8'd0},   1'b1, 32'hFF007D00, 32'hFF6DFF00},
    '{'{8'd0,   8'd255, 8'd255, 8'd255}, 1'b1, 32'hFF9000FF, 32'hFFFF84FF},
    '{'{8'd128, 8'd128, 8'd128, 8'd128}, 1'b1, 32'hFF808080, 32'hFF808080},
    '{'{8'd0,   8'd255, 8'd255, 8'd0},   1'b0, '0, '0},
    '{'{8'd255, 8'd0,   8'd0,   8'd255}, 1'b0, '0, '0},
    '{'{8'd16,  8'd128, 8'd235, 8'd128}, 1'b0, '0, '0},
    '{'{8'd81,  8'd90,  8'd145, 8'd240}, 1'b0, '0, '0},
    '{'{8'd41,  8'd240, 8'd82,  8'd110}, 1'b0, '0, '0},
    '{'{8'd170, 8'd166, 8'd210, 8'd16},  1'b0, '0, '0},
    '{'{8'hAA,  8'h55,  8'h55,  8'hAA},  1'b0, '0, '0},
    '{'{8'h55,  8'hAA,  8'hAA,  8'h55},  1'b0, '0, '0},
    '{'{8'd1,   8'd127, 8'd254, 8'd129}, 1'b0, '0, '0},
    '{'{8'd128, 8'd0,   8'd128, 8'd255}, 1'b0, '0, '0},
    '{'{8'd128, 8'd255, 8'd128, 8'd0},   1'b0, '0, '0}
  };

  function automatic logic [7:0] clamp_channel(input int level);
    if (level < 0) return 8'd0;
    if (level > 255) return 8'd255;
    return 8'(level);
  endfunction

  function automatic logic [31:0] color_of(input logic [7:0] luma, input logic [7:0] cb,
                                           input logic [7:0] cr);
    int y, u, v;
    logic [7:0] red, green, blue;
    y = luma;
    u = cb;
    v = cr;
    u = u - 128;
    v = v - 128;
    red   = clamp_channel(y + ((v * 37221) >>> 15));
    green = clamp_channel(y - ((u * 12975 + v * 18949) >>> 15));
    blue  = clamp_channel(y + ((u * 66883) >>> 15));
    return {8'hFF, red, green, blue};
  endfunction

  // expected pixel pair for one macropixel; advance the frame walk
  task automatic predict_pixel_pair(input yam_pkg::in_t px, input bit typed,
                                    input logic [31:0] t_first, input logic [31:0] t_second);
    int w, h;
    bit line_end, frame_done;
    yam_pkg::out_t first_px, second_px;
    w = width_reg & 12'hFFE;
    h = height_reg;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    line_end   = (int'(col_pos) + 2 >= w);
    frame_done = line_end && (int'(row_pos) + 1 >= h);
    first_px.pixel_address  = row_base + 22'(w - 1) - 22'(col_pos);
    first_px.pixel_argb     = typed ? t_first : color_of(px.luma_first, px.chroma_blue,
                                                         px.chroma_red);
    first_px.last_of_pair   = 1'b0;
    first_px.frame_end      = 1'b0;
    second_px.pixel_address = row_base + 22'(w - 2) - 22'(col_pos);
    second_px.pixel_argb    = typed ? t_second : color_of(px.luma_second, px.chroma_blue,
                                                          px.chroma_red);
    second_px.last_of_pair  = 1'b1;
    second_px.frame_end     = frame_done;
    pixel_queue.push_back(first_px);
    pixel_queue.push_back(second_px);
    if (frame_done) begin
      col_pos  = '0;
      row_pos  = '0;
      row_base = '0;
    end else if (line_end) begin
      col_pos  = '0;
      row_pos  = row_pos + 11'd1;
      row_base = row_base + 22'(w);
    end else begin
      col_pos = col_pos + 11'd2;
    end
  endtask

  task automatic send_macropixel(input yam_pkg::in_t px, input bit typed = 1'b0,
                                 input logic [31:0] t_first = '0,
                                 input logic [31:0] t_second = '0);
    int gap;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      yuyv_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    yuyv_valid <= 1'b1;
    yuyv       <= px;
    do @(posedge clk); while (!(yuyv_valid && !yuyv_stall));
    predict_pixel_pair(px, typed, t_first, t_second);
    macropixels_sent++;
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [11:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    // upper bits are junk: only the low 12 land in the register
    pwdata  <= ($urandom() & 32'hFFFF_F000) | {20'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_FRAME_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  // drop valid and wait until every expected pixel has come out
  task automatic drain_pixels();
    yuyv_valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic run_phase(input logic [11:0] w, input logic [11:0] h, input int count,
                           input bit gaps_allowed, input bit long_hold);
    yam_pkg::in_t px;
    drain_pixels();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    size_settings++;
    src_gaps  = gaps_allowed && ($urandom_range(0, 2) != 0);
    sink_gaps = gaps_allowed && ($urandom_range(0, 2) != 0);
    if (long_hold) begin
      src_gaps     = 1'b0;
      hold_request = 1'b1;
    end
    repeat (count) begin
      px = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
      send_macropixel(px);
    end
    yuyv_valid <= 1'b0;
  endtask

  // output side: random stall bursts plus a long hold-off on request
  initial begin
    int hold_left, burst_left;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        argb_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        argb_stall <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(1, 19) - 1;
        argb_stall <= 1'b1;
      end else begin
        argb_stall <= 1'b0;
      end
    end
  end

  // output checker and watchdog
  always @(posedge clk) begin
    yam_pkg::out_t want;
    if (!rst) begin
      if (argb_valid && !argb_stall) begin
        pixels_checked++;
        if (argb.frame_end) frame_ends_seen++;
        if (pixel_queue.size() == 0) begin
          $error("pixel transfer with nothing expected: addr %0d argb %h",
                 argb.pixel_address, argb.pixel_argb);
          error_count++;
        end else begin
          want = pixel_queue.pop_front();
          if (argb.pixel_address !== want.pixel_address) begin
            $error("pixel_address: expected %0d, got %0d", want.pixel_address,
                   argb.pixel_address);
            error_count++;
          end
          if (argb.pixel_argb !== want.pixel_argb) begin
            $error("pixel_argb: expected %h, got %h", want.pixel_argb, argb.pixel_argb);
            error_count++;
          end
          if (argb.last_of_pair !== want.last_of_pair) begin
            $error("last_of_pair: expected %b, got %b", want.last_of_pair,
                   argb.last_of_pair);
            error_count++;
          end
          if (argb.frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, got %b", want.frame_end, argb.frame_end);
            error_count++;
          end
        end
      end
      if ((argb_valid && !argb_stall) || (yuyv_valid && !yuyv_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("watchdog: no transfer for %0d cycles, %0d pixels pending",
                   STUCK_LIMIT, pixel_queue.size());
          $display("tb_yuyv_to_argb_mirror_converter: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [11:0] w, h;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset size 640 x 480
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    size_settings++;
    foreach (directed_rows[i])
      send_macropixel(directed_rows[i].px, directed_rows[i].typed,
                      directed_rows[i].argb_first, directed_rows[i].argb_second);

    run_phase(12'd2, 12'd1, 20, 1'b1, 1'b0);       // every macropixel ends a frame
    run_phase(12'd6, 12'd3, 40, 1'b1, 1'b0);
    run_phase(12'd7, 12'd2, 30, 1'b1, 1'b0);       // odd width
    run_phase(12'd0, 12'd0, 20, 1'b1, 1'b0);       // saturate up to 2 x 1
    run_phase(12'd4095, 12'd4095, 30, 1'b1, 1'b0); // saturate down to max
    run_phase(12'd2048, 12'd2048, 25, 1'b1, 1'b0);
    run_phase(12'd4, 12'd2, 30, 1'b1, 1'b0);       // column past new width
    run_phase(12'd6, 12'd40, 30, 1'b1, 1'b0);
    run_phase(12'd6, 12'd2, 20, 1'b1, 1'b0);       // row past new height
    run_phase(12'd16, 12'd4, 40, 1'b1, 1'b1);      // long output hold-off

    while (macropixels_sent < ITEM_TARGET - TAIL_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = 12'd0;
        1:       w = 12'd1;
        2:       w = 12'd4095;
        3:       w = 12'd2048;
        default: w = 12'($urandom_range(2, 24));
      endcase
      case ($urandom_range(0, 7))
        0:       h = 12'd0;
        1:       h = 12'd4095;
        default: h = 12'($urandom_range(1, 6));
      endcase
      run_phase(w, h, $urandom_range(15, 50), 1'b1, 1'b0);
    end

    run_phase(12'd8, 12'd3, TAIL_ITEMS, 1'b0, 1'b0);
    drain_pixels();
    repeat (10) @(posedge clk);

    $display("covered %0d macropixels and %0d pixels over %0d frame sizes",
             macropixels_sent, pixels_checked, size_settings);
    $display("saw %0d frame ends, %0d mismatches", frame_ends_seen, error_count);
    if (error_count == 0) begin
      $display("tb_yuyv_to_argb_mirror_converter: done, clean");
    end else begin
      $display("tb_yuyv_to_argb_mirror_converter: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/yam_pkg.sv
src/yam_addr_gen.sv
src/yam_color.sv
src/yam_out_ser.sv
src/yuyv_to_argb_mirror_converter.sv
tb/tb_yuyv_to_argb_mirror_converter.sv
